### src/t8ex_pkg.sv
package t8ex_pkg;

    // instruction groups, opcode byte bits 7:6
    localparam logic [1:0] GRP_MOVE  = 2'd0;
    localparam logic [1:0] GRP_ARITH = 2'd1;
    localparam logic [1:0] GRP_LOGIC = 2'd2;
    localparam logic [1:0] GRP_JUMP  = 2'd3;

    // operations, opcode byte bits 5:4, per group
    localparam logic [1:0] OP_LDI   = 2'd0;
    localparam logic [1:0] OP_LD    = 2'd1;
    localparam logic [1:0] OP_ST    = 2'd2;
    localparam logic [1:0] OP_MOV   = 2'd3;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_MUL   = 2'd2;
    localparam logic [1:0] OP_ADDI  = 2'd3;

    localparam logic [1:0] OP_AND   = 2'd0;
    localparam logic [1:0] OP_OR    = 2'd1;
    localparam logic [1:0] OP_XOR   = 2'd2;
    localparam logic [1:0] OP_NOT   = 2'd3;

    localparam logic [1:0] OP_JMP   = 2'd0;
    localparam logic [1:0] OP_JMPZ  = 2'd1;
    localparam logic [1:0] OP_JMPNZ = 2'd2;
    localparam logic [1:0] OP_HLT   = 2'd3;

    // status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_UNSUP = 1'b1;

    // register map, index is paddr[2]
    localparam int  APB_AW      = 3;
    localparam logic REG_ENTRY  = 1'b0;
    localparam logic [7:0] ENTRY_RESET = 8'h40;

    // pc step for a two-byte instruction
    localparam logic [7:0] PC_STEP = 8'd2;

    typedef struct packed {
        logic [7:0] dest_value;
        logic [3:0] dest_index;
        logic       reg_written;
        logic       halted;
        logic [7:0] next_pc;
    } t_result;

endpackage

### src/toy_8bit_cpu_execute.sv
// Execute stage of a small 8-bit processor. Each input beat carries one two-byte
// instruction (opcode byte in tdata[7:0], operand byte in tdata[15:8]); each output
// beat gives the next pc, the halt flag and the register write-back, with the status
// bit on tuser (1 = unsupported return form, LDI to r0, executed as a no-op). The
// register file and the data memory sit in synchronous RAMs with a registered read.
// An instruction's operands are read at the edge that accepts it; the instruction is
// executed and written back at the edge on which it leaves the execute stage, which
// is held while the output register is full and not drained. Results leave through
// the output register. A new beat is taken every cycle as long as it is drained. A
// write made at the same edge as the next instruction's read is bypassed into that
// instruction. Reset clears the registers and the data memory through per-entry valid
// bits, so no clearing pass is run and beats are taken right after reset. Writing
// entry_address (APB byte address 0) also loads the program counter; write it only
// while no beat is in flight. Once HLT has executed, every later beat returns the held
// pc with halted set and changes nothing.
module toy_8bit_cpu_execute #(
    parameter int REG_COUNT = 16,
    parameter int MEM_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // instruction beats
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // opcode_byte, operand_byte
    // result beats
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // next_pc, halted, reg_written,
                                                   // dest_index, dest_value, zero pad
    output logic                        m_tuser,   // status
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [t8ex_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import t8ex_pkg::*;

    localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MA = $clog2(MEM_DEPTH);

    // configuration and architectural state
    logic [7:0] r_entry;
    logic [7:0] r_pc;
    logic       r_halt;
    logic       cfg_wr;

    // per-entry valid bits stand in for the reset clear of both stores
    logic [REG_COUNT-1:0] r_reg_vld;
    logic [MEM_DEPTH-1:0] r_mem_vld;

    // execute stage (data from the RAMs arrives here)
    logic       r_s1_vld;
    logic [7:0] r_s1_opc;
    logic [7:0] r_s1_opr;
    logic       r_s1_a_ok;   // rd in range and written since reset
    logic       r_s1_b_ok;
    logic       r_s1_m_ok;
    logic       r_s1_byp;    // previous instruction executed on the accept edge

    // last write-back, for the bypass
    logic       r_lw_reg_we;
    logic [3:0] r_lw_reg_idx;
    logic [7:0] r_lw_reg_val;
    logic       r_lw_mem_we;
    logic [7:0] r_lw_mem_addr;
    logic [7:0] r_lw_mem_val;

    // output register
    logic       r_out_vld;
    t_result    r_out;
    logic       r_out_st;

    logic       s_acc;
    logic       s1_fire;
    logic [7:0] acc_opc;
    logic [7:0] acc_opr;
    logic [3:0] acc_rd;
    logic [3:0] acc_rs;
    logic       acc_rd_in;
    logic       acc_rs_in;
    logic       acc_m_in;

    logic [7:0] rf_a_q;
    logic [7:0] rf_b_q;
    logic [7:0] dm_q;

    logic [1:0] grp;
    logic [1:0] op;
    logic [3:0] rd;
    logic [3:0] rs;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] m;
    logic [7:0] prod;
    logic       rd_in;
    logic       m_in;

    logic       n_wr;
    logic [7:0] n_val;
    logic [7:0] n_pc;
    logic       n_halt;
    logic       n_st;
    logic       n_mem_we;
    t_result    n_out;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY);
    assign prdata = (paddr[2] == REG_ENTRY) ? {24'd0, r_entry} : 32'd0;

    // ---------------- handshakes ----------------
    assign s1_fire  = r_s1_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_s1_vld || s1_fire;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- read side ----------------
    assign acc_opc   = s_tdata[7:0];
    assign acc_opr   = s_tdata[15:8];
    assign acc_rd    = acc_opc[3:0];
    assign acc_rs    = acc_opr[3:0];
    assign acc_rd_in = (int'(acc_rd) < REG_COUNT);
    assign acc_rs_in = (int'(acc_rs) < REG_COUNT);
    assign acc_m_in  = (int'(acc_opr) < MEM_DEPTH);

    // two copies of the register file give the two read ports
    t8ex_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (s1_fire && n_wr),
        .i_waddr (rd[RA-1:0]),
        .i_wdata (n_val),
        .i_re    (s_acc),
        .i_raddr (acc_rd[RA-1:0]),
        .o_rdata (rf_a_q)
    );

    t8ex_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (s1_fire && n_wr),
        .i_waddr (rd[RA-1:0]),
        .i_wdata (n_val),
        .i_re    (s_acc),
        .i_raddr (acc_rs[RA-1:0]),
        .o_rdata (rf_b_q)
    );

    t8ex_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (s1_fire && n_mem_we),
        .i_waddr (r_s1_opr[MA-1:0]),
        .i_wdata (a),
        .i_re    (s_acc),
        .i_raddr (acc_opr[MA-1:0]),
        .o_rdata (dm_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_opc  <= acc_opc;
            r_s1_opr  <= acc_opr;
            r_s1_a_ok <= acc_rd_in && r_reg_vld[acc_rd[RA-1:0]];
            r_s1_b_ok <= acc_rs_in && r_reg_vld[acc_rs[RA-1:0]];
            r_s1_m_ok <= acc_m_in && r_mem_vld[acc_opr[MA-1:0]];
            r_s1_byp  <= s1_fire;
        end
    end

    // ---------------- execute ----------------
    assign grp   = r_s1_opc[7:6];
    assign op    = r_s1_opc[5:4];
    assign rd    = r_s1_opc[3:0];
    assign rs    = r_s1_opr[3:0];
    assign rd_in = (int'(rd) < REG_COUNT);
    assign m_in  = (int'(r_s1_opr) < MEM_DEPTH);

    // operand select: bypass of the write made on the accept edge, else RAM, else zero
    always_comb begin
        if (r_s1_byp && r_lw_reg_we && (r_lw_reg_idx == rd)) begin
            a = r_lw_reg_val;
        end else begin
            a = r_s1_a_ok ? rf_a_q : 8'd0;
        end
        if (r_s1_byp && r_lw_reg_we && (r_lw_reg_idx == rs)) begin
            b = r_lw_reg_val;
        end else begin
            b = r_s1_b_ok ? rf_b_q : 8'd0;
        end
        if (r_s1_byp && r_lw_mem_we && (r_lw_mem_addr == r_s1_opr)) begin
            m = r_lw_mem_val;
        end else begin
            m = r_s1_m_ok ? dm_q : 8'd0;
        end
    end

    assign prod = 8'(16'(a) * 16'(b));

    always_comb begin
        n_wr     = 1'b0;
        n_val    = 8'd0;
        n_pc     = r_pc + PC_STEP;
        n_halt   = r_halt;
        n_st     = ST_OK;
        n_mem_we = 1'b0;
        case (grp)
            GRP_MOVE: begin
                case (op)
                    OP_LDI: begin
                        if (rd == 4'd0) begin
                            n_st = ST_UNSUP;   // return form
                        end else begin
                            n_wr  = 1'b1;
                            n_val = r_s1_opr;
                        end
                    end
                    OP_LD: begin
                        n_wr  = 1'b1;
                        n_val = m;
                    end
                    OP_ST: begin
                        n_mem_we = m_in;
                    end
                    default: begin
                        n_wr  = 1'b1;
                        n_val = b;
                    end
                endcase
            end
            GRP_ARITH: begin
                n_wr = 1'b1;
                case (op)
                    OP_ADD:  n_val = a + b;
                    OP_SUB:  n_val = a - b;
                    OP_MUL:  n_val = prod;
                    default: n_val = a + r_s1_opr;
                endcase
            end
            GRP_LOGIC: begin
                n_wr = 1'b1;
                case (op)
                    OP_AND:  n_val = a & b;
                    OP_OR:   n_val = a | b;
                    OP_XOR:  n_val = a ^ b;
                    default: n_val = ~b;
                endcase
            end
            default: begin
                case (op)
                    OP_JMP:   n_pc = r_s1_opr;
                    OP_JMPZ:  if (a == 8'd0) n_pc = r_s1_opr;
                    OP_JMPNZ: if (a != 8'd0) n_pc = r_s1_opr;
                    default:  n_halt = 1'b1;
                endcase
            end
        endcase

        // writes past the register file are dropped
        if (!rd_in) begin
            n_wr  = 1'b0;
            n_val = 8'd0;
        end

        // halted: nothing changes, pc held
        if (r_halt) begin
            n_wr     = 1'b0;
            n_val    = 8'd0;
            n_pc     = r_pc;
            n_st     = ST_OK;
            n_mem_we = 1'b0;
        end

        n_out.next_pc     = n_pc;
        n_out.halted      = n_halt;
        n_out.reg_written = n_wr;
        n_out.dest_index  = n_wr ? rd : 4'd0;
        n_out.dest_value  = n_val;
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= ENTRY_RESET;
            r_pc        <= ENTRY_RESET;
            r_halt      <= 1'b0;
            r_reg_vld   <= '0;
            r_mem_vld   <= '0;
            r_lw_reg_we <= 1'b0;
            r_lw_mem_we <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_entry <= pwdata[7:0];
                r_pc    <= pwdata[7:0];
            end
            if (s1_fire) begin
                r_pc        <= n_pc;
                r_halt      <= n_halt;
                r_lw_reg_we <= n_wr;
                r_lw_mem_we <= n_mem_we;
                if (n_wr) begin
                    r_reg_vld[rd[RA-1:0]] <= 1'b1;
                end
                if (n_mem_we) begin
                    r_mem_vld[r_s1_opr[MA-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_lw_reg_idx  <= rd;
            r_lw_reg_val  <= n_val;
            r_lw_mem_addr <= r_s1_opr;
            r_lw_mem_val  <= a;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out    <= n_out;
            r_out_st <= n_st;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {2'b00, r_out.dest_value, r_out.dest_index, r_out.reg_written,
                       r_out.halted, r_out.next_pc};
    assign m_tuser  = r_out_st;

`ifndef SYNTH
    // halt flag is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // a halting or halted result never writes a register and is never flagged
    a_halt_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.halted) |-> (!r_out.reg_written && r_out_st == ST_OK))
        else $error("write-back while halted");

    // no write-back means zero index and value
    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.reg_written) |->
        (r_out.dest_index == 4'd0 && r_out.dest_value == 8'd0))
        else $error("stale write-back fields");

    // a stalled instruction keeps its operands until it executes
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_fire) |=> (r_s1_vld && $stable(r_s1_opc) && $stable(r_s1_opr)))
        else $error("execute stage lost its instruction");
`endif

endmodule

### src/t8ex_ram.sv
module t8ex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
